FILE: rtl/register_free_list_top_macros.svh
// Assertion macros for the free list port checker.
`ifndef REGISTER_FREE_LIST_TOP_MACROS_SVH
`define REGISTER_FREE_LIST_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RFL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("free list check failed");

// Next-cycle implication, disabled in reset.
`define RFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("free list check failed");

`endif

FILE: rtl/rfl_pkg.sv
// Types and constants for the register free list.
package rfl_pkg;

  localparam int POOL_DEPTH   = 64;
  localparam int REG_NUM_BITS = 10;
  localparam int REG_W        = 10;
  localparam int IDX_W        = $clog2(POOL_DEPTH);
  localparam int CNT_W        = $clog2(POOL_DEPTH + 1);
  localparam int MEM_DEPTH    = 2 * POOL_DEPTH;
  localparam int MEM_AW       = IDX_W + 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] POOL_INT = 2'd0;
  localparam logic [1:0] POOL_FLT = 2'd1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_NOTTEMP = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POP,
    S_RESP
  } state_t;

endpackage

FILE: rtl/rfl_if.sv
// Request and response channel interfaces of the register free list.
interface rfl_req_if import rfl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [1:0]       pool;
  logic [REG_W-1:0] reg_num;

  modport source (output valid, op, pool, reg_num, input ready);
  modport sink   (input valid, op, pool, reg_num, output ready);
endinterface

interface rfl_rsp_if import rfl_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [1:0]       pool_out;
  logic [REG_W-1:0] reg_out;

  modport source (output valid, status, pool_out, reg_out, input ready);
  modport sink   (input valid, status, pool_out, reg_out, output ready);
endinterface

FILE: rtl/register_free_list_top.sv
// Register free list: two LIFO pools with a sequential duplicate scan.
// An allocate from a non-empty pool passes through S_POP, which takes the popped entry
//   off the stack memory's registered read port; a free onto a non-empty pool scans in
//   S_SCAN, one compare per cycle; an empty pool or a non-pool code goes to S_RESP.
// A new request is taken only once the last result is loaded out, so output stalls hold requests off.
// Synchronous active-low reset empties both pools; no clearing pass is needed.
module register_free_list_top import rfl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rfl_req_if.sink   in_ch,
  rfl_rsp_if.source out_ch
);

  state_t              state_r, state_nxt;
  logic                op_r, op_nxt;
  logic [1:0]          pool_r, pool_nxt;
  logic [REG_NUM_BITS-1:0] num_r, num_nxt;
  logic [CNT_W-1:0]    int_cnt_r, int_cnt_nxt;
  logic [CNT_W-1:0]    flt_cnt_r, flt_cnt_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [REG_NUM_BITS-1:0] res_reg_r, res_reg_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r;
  logic [1:0]          out_pool_r;
  logic [REG_NUM_BITS-1:0] out_reg_r;

  logic [REG_NUM_BITS-1:0] mem [MEM_DEPTH];
  logic [REG_NUM_BITS-1:0] rd_data_r;
  logic                mem_we;
  logic [MEM_AW-1:0]   mem_waddr;
  logic [MEM_AW-1:0]   mem_raddr;
  logic [REG_NUM_BITS-1:0] mem_wdata;

  logic                accept;
  logic [CNT_W-1:0]    acc_cnt;
  logic [CNT_W-1:0]    acc_cnt_m1;
  logic [CNT_W-1:0]    cur_cnt;
  logic                match;
  logic                scan_issue;
  logic                scan_end;
  logic                out_load;

  assign accept     = in_ch.valid && in_ch.ready;
  assign acc_cnt    = in_ch.pool[0] ? flt_cnt_r : int_cnt_r;
  assign acc_cnt_m1 = acc_cnt - CNT_W'(1);
  assign cur_cnt    = pool_r[0] ? flt_cnt_r : int_cnt_r;
  assign match      = rd_vld_r && (rd_data_r == num_r);
  assign scan_issue = (idx_r != cur_cnt);
  assign scan_end   = rd_vld_r && !match && !scan_issue;
  assign out_load   = (state_r == S_RESP) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.pool_out = out_pool_r;
  assign out_ch.reg_out  = REG_W'(out_reg_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority if (in_ch.pool[1]) state_nxt = S_RESP;
          else if (in_ch.op == OP_ALLOC) state_nxt = (acc_cnt == '0) ? S_RESP : S_POP;
          else state_nxt = (acc_cnt == '0) ? S_RESP : S_SCAN;
        end
      end
      S_SCAN: begin
        if (match || scan_end) state_nxt = S_RESP;
      end
      S_POP:  state_nxt = S_RESP;
      S_RESP: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_nxt         = op_r;
    pool_nxt       = pool_r;
    num_nxt        = num_r;
    int_cnt_nxt    = int_cnt_r;
    flt_cnt_nxt    = flt_cnt_r;
    idx_nxt        = idx_r;
    rd_vld_nxt     = 1'b0;
    res_status_nxt = res_status_r;
    res_reg_nxt    = res_reg_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = num_r;
    mem_raddr      = {pool_r[0], idx_r[IDX_W-1:0]};
    unique case (state_r)
      S_IDLE: begin
        mem_raddr = {in_ch.pool[0], acc_cnt_m1[IDX_W-1:0]};
        if (accept) begin
          op_nxt      = in_ch.op;
          pool_nxt    = in_ch.pool;
          num_nxt     = in_ch.reg_num[REG_NUM_BITS-1:0];
          idx_nxt     = '0;
          res_reg_nxt = '0;
          priority if (in_ch.pool[1]) begin
            res_status_nxt = ST_NOTTEMP;
          end else if (in_ch.op == OP_ALLOC) begin
            if (acc_cnt == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              res_status_nxt = ST_OK;
              if (in_ch.pool[0]) flt_cnt_nxt = acc_cnt_m1;
              else int_cnt_nxt = acc_cnt_m1;
            end
          end else if (acc_cnt == '0) begin
            // empty pool: nothing to scan, push at once
            res_status_nxt = ST_OK;
            mem_we         = 1'b1;
            mem_waddr      = {in_ch.pool[0], {IDX_W{1'b0}}};
            mem_wdata      = in_ch.reg_num[REG_NUM_BITS-1:0];
            if (in_ch.pool[0]) flt_cnt_nxt = CNT_W'(1);
            else int_cnt_nxt = CNT_W'(1);
          end
        end
      end
      S_SCAN: begin
        // read entry idx, compare it in the next cycle
        rd_vld_nxt = scan_issue;
        if (scan_issue) idx_nxt = idx_r + CNT_W'(1);
        priority if (match) begin
          res_status_nxt = ST_DUP;
        end else if (scan_end) begin
          if (cur_cnt == CNT_W'(POOL_DEPTH)) begin
            res_status_nxt = ST_FULL;
          end else begin
            res_status_nxt = ST_OK;
            mem_we         = 1'b1;
            mem_waddr      = {pool_r[0], cur_cnt[IDX_W-1:0]};
            if (pool_r[0]) flt_cnt_nxt = cur_cnt + CNT_W'(1);
            else int_cnt_nxt = cur_cnt + CNT_W'(1);
          end
        end
      end
      S_POP: begin
        res_reg_nxt = rd_data_r;
      end
      S_RESP: ;
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      int_cnt_r   <= '0;
      flt_cnt_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      int_cnt_r   <= int_cnt_nxt;
      flt_cnt_r   <= flt_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pool_r       <= pool_nxt;
    num_r        <= num_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_reg_r    <= res_reg_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_pool_r   <= pool_r;
      out_reg_r    <= (op_r == OP_ALLOC && res_status_r == ST_OK) ? res_reg_r : '0;
    end
  end

  // stack memory: both pools, pool select in the top address bit
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[mem_raddr];
  end

endmodule

FILE: rtl/rfl_checker.sv
// Port-level checker for the register free list, bound to the top level.
`include "register_free_list_top_macros.svh"

module rfl_checker import rfl_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       out_status,
  input logic [1:0]       out_pool,
  input logic [REG_W-1:0] out_reg
);

  // a pending response holds until transferred
  `RFL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // every accepted request leaves the idle state, so ready drops after a transfer
  `RFL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // non-pool codes always come back as not temporary
  `RFL_ASSERT_NOW(a_nottemp, out_valid && out_pool[1], out_status == ST_NOTTEMP)

  // a failed result carries no register number
  `RFL_ASSERT_NOW(a_reg_zero, out_valid && out_status != ST_OK, out_reg == '0)

endmodule

bind register_free_list_top rfl_checker u_rfl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_pool   (out_ch.pool_out),
  .out_reg    (out_ch.reg_out)
);

FILE: tb/free_list_checker.sv
// Checker for the register free list: tracks both pools and compares every result transfer.
`timescale 1ns / 1ps

module free_list_checker import rfl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rfl_req_if   req,
  rfl_rsp_if   rsp,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    status_t          status;
    logic [1:0]       pool;
    logic [REG_W-1:0] reg_num;
  } pool_outcome_t;

  // index 0 is the integer pool, index 1 the float pool
  logic [REG_NUM_BITS-1:0] pool_stack [2][POOL_DEPTH];
  int                      pool_fill  [2];
  pool_outcome_t           outcome_q  [$];

  function automatic pool_outcome_t predict_pool_op(input logic op, input logic [1:0] pool,
                                                    input logic [REG_W-1:0] num);
    pool_outcome_t           res;
    logic                    dup;
    int                      p;
    logic [REG_NUM_BITS-1:0] key;
    res.status  = ST_OK;
    res.pool    = pool;
    res.reg_num = '0;
    p           = (pool == POOL_FLT) ? 1 : 0;
    key         = num[REG_NUM_BITS-1:0];
    dup         = 1'b0;
    if (pool != POOL_INT && pool != POOL_FLT) begin
      res.status = ST_NOTTEMP;
    end else if (op == OP_ALLOC) begin
      if (pool_fill[p] == 0) begin
        res.status = ST_EMPTY;
      end else begin
        pool_fill[p]--;
        res.reg_num = REG_W'(pool_stack[p][pool_fill[p]]);
      end
    end else begin
      // duplicate check takes priority over the full check
      for (int i = 0; i < pool_fill[p]; i++)
        if (pool_stack[p][i] == key) dup = 1'b1;
      if (dup) begin
        res.status = ST_DUP;
      end else if (pool_fill[p] == POOL_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pool_stack[p][pool_fill[p]] = key;
        pool_fill[p]++;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pool_outcome_t want;
    if (!rst_n) begin
      outcome_q.delete();
      pool_fill[0] = 0;
      pool_fill[1] = 0;
      pending      <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result transfer with no request outstanding: status %0d pool %0d reg %0d",
                 rsp.status, rsp.pool_out, rsp.reg_out);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.pool_out !== want.pool) begin
            $error("pool_out: expected %0d, actual %0d", want.pool, rsp.pool_out);
            errors++;
          end
          if (rsp.reg_out !== want.reg_num) begin
            $error("reg_out: expected %0d, actual %0d", want.reg_num, rsp.reg_out);
            errors++;
          end
        end
      end
      if (req.valid && req.ready)
        outcome_q.insert(outcome_q.size(), predict_pool_op(req.op, req.pool, req.reg_num));
      pending <= outcome_q.size();
    end
  end

endmodule

FILE: tb/tb_register_free_list_top.sv
// Testbench top for the register free list: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_register_free_list_top;
  import rfl_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 120;
  localparam int SEGMENTS       = 9;
  localparam int SEG_ITEMS      = 148;
  localparam int HISTORY_DEPTH  = 96;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic rsp_ready = 1'b0;

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_reqs     = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int fail_count;
  int outstanding;

  logic [REG_W-1:0] freed_nums [$];

  rfl_req_if in_ch ();
  rfl_rsp_if out_ch ();

  assign out_ch.ready = rsp_ready;

  register_free_list_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  free_list_checker CHK (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (in_ch),
    .rsp     (out_ch),
    .errors  (fail_count),
    .pending (outstanding)
  );

  always #5 clk = ~clk;

  // result side: random stalls, plus a long hold whenever one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (holds_done != hold_reqs) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("register_free_list_top: mismatch");
      $finish;
    end
  end

  task automatic set_idling(input int phase);
    case (phase)
      0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1: begin src_idle_pct = 68; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 68; end
      default: begin src_idle_pct = 21; snk_stall_pct = 21; end
    endcase
  endtask

  task automatic send_req(input logic op, input logic [1:0] pool, input logic [REG_W-1:0] num);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.pool    <= pool;
    in_ch.reg_num <= num;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_FREE) begin
      freed_nums.insert(freed_nums.size(), num);
      if (freed_nums.size() > HISTORY_DEPTH) void'(freed_nums.pop_front());
    end
  endtask

  // drop valid and hold off until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic send_random(input int mode, input logic [1:0] hot_pool);
    logic             op;
    logic [1:0]       pool;
    logic [REG_W-1:0] num;
    int               r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  op = (r < 85) ? OP_FREE : OP_ALLOC;
      MODE_DRAIN: op = (r < 25) ? OP_FREE : OP_ALLOC;
      default:    op = (r < 50) ? OP_FREE : OP_ALLOC;
    endcase
    r = $urandom_range(0, 99);
    if (r < 8)       pool = 2'($urandom_range(2, 3));
    else if (r < 80) pool = hot_pool;
    else             pool = (hot_pool == POOL_INT) ? POOL_FLT : POOL_INT;
    // reuse recently freed numbers so duplicate frees actually occur
    if (op == OP_FREE && freed_nums.size() > 0 && $urandom_range(0, 99) < 30)
      num = freed_nums[$urandom_range(0, freed_nums.size() - 1)];
    else
      num = REG_W'($urandom_range(0, (1 << REG_W) - 1));
    send_req(op, pool, num);
  endtask

  initial begin
    int seg;
    int k;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_ALLOC;
    in_ch.pool    = POOL_INT;
    in_ch.reg_num = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    set_idling(0);
    // empty pools, non-temporary codes, extremes, duplicates, LIFO order
    send_req(OP_ALLOC, POOL_INT, 10'd0);
    send_req(OP_ALLOC, POOL_FLT, 10'd1023);
    send_req(OP_ALLOC, 2'd2,     10'd5);
    send_req(OP_FREE,  2'd2,     10'd1023);
    send_req(OP_FREE,  2'd3,     10'd0);
    send_req(OP_ALLOC, 2'd3,     10'd1023);
    send_req(OP_FREE,  POOL_INT, 10'd0);
    send_req(OP_FREE,  POOL_INT, 10'd1023);
    send_req(OP_FREE,  POOL_INT, 10'd0);
    send_req(OP_FREE,  POOL_FLT, 10'd1023);
    send_req(OP_FREE,  POOL_FLT, 10'h2AA);
    send_req(OP_FREE,  POOL_FLT, 10'h155);
    send_req(OP_FREE,  POOL_FLT, 10'd1023);
    send_req(OP_ALLOC, POOL_INT, 10'd7);
    send_req(OP_ALLOC, POOL_INT, 10'd7);
    send_req(OP_ALLOC, POOL_INT, 10'd7);
    send_req(OP_FREE,  POOL_INT, 10'd1023);
    send_req(OP_ALLOC, POOL_FLT, 10'd0);
    send_req(OP_ALLOC, POOL_FLT, 10'd0);
    send_req(OP_ALLOC, POOL_FLT, 10'd0);
    send_req(OP_ALLOC, POOL_FLT, 10'd0);
    wait_drained();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      set_idling(seg % 4);
      for (k = 0; k < SEG_ITEMS; k++) begin
        if (seg == 4 && k == 20) hold_reqs++;
        send_random(seg % 3, (seg % 2 == 0) ? POOL_INT : POOL_FLT);
      end
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("register_free_list_top: match");
    else
      $display("register_free_list_top: mismatch");
    $finish;
  end

endmodule
